[sv/pdsd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pdsd_pkg;

  // Operand and product widths of the shared multiplier
  localparam int MUL_A_W = 17;
  localparam int MUL_B_W = 22;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Accumulator width for the regulator sum
  localparam int ACC_W = 40;

  typedef logic signed [MUL_A_W-1:0] mul_a_t;
  typedef logic signed [MUL_B_W-1:0] mul_b_t;
  typedef logic signed [MUL_P_W-1:0] mul_p_t;
  typedef logic signed [ACC_W-1:0]   acc_t;

  function automatic logic signed [15:0] sat16(input acc_t v);
    logic signed [15:0] r;
    if (v > acc_t'(32767)) begin
      r = 16'sh7fff;
    end else if (v < -acc_t'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/pdsd_mul.sv]
`timescale 1ns / 1ps
`default_nettype none

module pdsd_mul (
  input  wire              clk,
  input  wire pdsd_pkg::mul_a_t a,
  input  wire pdsd_pkg::mul_b_t b,
  output pdsd_pkg::mul_p_t p
);

  always_ff @(posedge clk) begin
    p <= pdsd_pkg::mul_p_t'(a) * pdsd_pkg::mul_p_t'(b);
  end

endmodule

`default_nettype wire

[sv/pi_distance_steering_drive.sv]
`timescale 1ns / 1ps
`default_nettype none

// PI distance regulator with steering mix.
// Input channel (in_valid / in_stall) carries one sample: distance (unsigned
// Q8.8, zero = no target) and line_position (pixel column). Output channel
// (out_valid / out_stall) returns one beat per sample: right_speed,
// left_speed and target_seen.
// A sample with a target runs from accept to out_valid through the states
// ERR, INT, MKI, ACC, SPD, MSS, MST, MIX and FIN: a small sequencer drives
// one shared 17x22 multiplier (registered product) four times (kp*error,
// ki*integral, speed_scale*speed, steer_scale*steer), with add, truncate and
// saturate steps in between. A sample with distance zero skips the arithmetic
// and goes from ERR straight to FIN. The next sample is accepted once the
// sequencer is back in idle, not while a sample is still in progress.
// A finished beat sits in the output register while the receiver stalls; the
// next sample may already be accepted, and its result waits in the last
// step until the output register is free.
// Reset (rst, synchronous) clears the integral, loads the register defaults
// and empties the output register. Registers are written over the APB port
// at byte address 4*index; pready is always high.
module pi_distance_steering_drive #(
  parameter int LINE_WIDTH_PIXELS = 640
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire        [15:0] distance,
  input  wire        [9:0]  line_position,
  output logic              out_valid,
  input  wire               out_stall,
  output logic signed [15:0] right_speed,
  output logic signed [15:0] left_speed,
  output logic              target_seen,
  input  wire               psel,
  input  wire               penable,
  input  wire               pwrite,
  input  wire        [4:0]  paddr,
  input  wire        [31:0] pwdata,
  output logic       [31:0] prdata,
  output logic              pready
);

  localparam logic signed [10:0] LINE_HALF = 11'(LINE_WIDTH_PIXELS / 2);

  localparam logic [2:0] REG_GOAL   = 3'd0;
  localparam logic [2:0] REG_EDB    = 3'd1;
  localparam logic [2:0] REG_ILIM   = 3'd2;
  localparam logic [2:0] REG_KP     = 3'd3;
  localparam logic [2:0] REG_KI     = 3'd4;
  localparam logic [2:0] REG_SDB    = 3'd5;
  localparam logic [2:0] REG_SPSCL  = 3'd6;
  localparam logic [2:0] REG_STSCL  = 3'd7;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_ERR  = 4'd1;
  localparam logic [3:0] ST_INT  = 4'd2;
  localparam logic [3:0] ST_MKI  = 4'd3;
  localparam logic [3:0] ST_ACC  = 4'd4;
  localparam logic [3:0] ST_SPD  = 4'd5;
  localparam logic [3:0] ST_MSS  = 4'd6;
  localparam logic [3:0] ST_MST  = 4'd7;
  localparam logic [3:0] ST_MIX  = 4'd8;
  localparam logic [3:0] ST_FIN  = 4'd9;

  // configuration
  logic [15:0] setpoint;
  logic [15:0] error_deadband;
  logic [19:0] integral_limit;
  logic [15:0] proportional_gain;
  logic [15:0] integral_gain;
  logic [9:0]  steer_deadband;
  logic [7:0]  speed_scale;
  logic [7:0]  steer_scale;

  logic [3:0]          state;
  logic [15:0]         meas;
  logic [9:0]          line;
  logic signed [16:0]  err;
  logic signed [10:0]  steer;
  logic signed [21:0]  integ;
  logic                active;
  logic signed [15:0]  speed;
  pdsd_pkg::acc_t      acc;
  logic signed [15:0]  res_right;
  logic signed [15:0]  res_left;
  logic                res_seen;

  pdsd_pkg::mul_a_t mul_a;
  pdsd_pkg::mul_b_t mul_b;
  pdsd_pkg::mul_p_t mul_p;

  logic               cfg_wr;
  logic [2:0]         cfg_idx;
  logic [16:0]        err_abs;
  logic               err_outside;
  logic [10:0]        steer_abs;
  logic signed [21:0] sum;
  logic signed [21:0] lim;
  logic signed [21:0] sum_clamped;
  pdsd_pkg::acc_t     acc_adj;
  pdsd_pkg::acc_t     acc_q;
  pdsd_pkg::acc_t     prod_ext;
  logic               out_free;

  pdsd_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite;
  assign cfg_idx  = paddr[4:2];
  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    case (cfg_idx)
      REG_GOAL:  prdata = {16'd0, setpoint};
      REG_EDB:   prdata = {16'd0, error_deadband};
      REG_ILIM:  prdata = {12'd0, integral_limit};
      REG_KP:    prdata = {16'd0, proportional_gain};
      REG_KI:    prdata = {16'd0, integral_gain};
      REG_SDB:   prdata = {22'd0, steer_deadband};
      REG_SPSCL: prdata = {24'd0, speed_scale};
      REG_STSCL: prdata = {24'd0, steer_scale};
      default:   prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint          <= 16'd2560;
      error_deadband    <= 16'd128;
      integral_limit    <= 20'd262144;
      proportional_gain <= 16'd2048;
      integral_gain     <= 16'd90;
      steer_deadband    <= 10'd10;
      speed_scale       <= 8'd2;
      steer_scale       <= 8'd2;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_GOAL:  setpoint          <= pwdata[15:0];
        REG_EDB:   error_deadband    <= pwdata[15:0];
        REG_ILIM:  integral_limit    <= pwdata[19:0];
        REG_KP:    proportional_gain <= pwdata[15:0];
        REG_KI:    integral_gain     <= pwdata[15:0];
        REG_SDB:   steer_deadband    <= pwdata[9:0];
        REG_SPSCL: speed_scale       <= pwdata[7:0];
        REG_STSCL: steer_scale       <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    err_abs     = err[16] ? 17'(-err) : 17'(err);
    err_outside = (err_abs >= 17'(error_deadband));
    steer_abs   = steer[10] ? 11'(-steer) : 11'(steer);
    sum         = integ + 22'(err);
    lim         = 22'(integral_limit);
    if (sum > lim) begin
      sum_clamped = lim;
    end else if (sum < -lim) begin
      sum_clamped = -lim;
    end else begin
      sum_clamped = sum;
    end
    // truncate toward zero on the Q16.16 -> integer step
    acc_adj  = acc[pdsd_pkg::ACC_W-1] ? acc + pdsd_pkg::acc_t'(65535) : acc;
    acc_q    = acc_adj >>> 16;
    prod_ext = pdsd_pkg::acc_t'(mul_p);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_INT: begin
        mul_a = pdsd_pkg::mul_a_t'({1'b0, proportional_gain});
        mul_b = pdsd_pkg::mul_b_t'(err);
      end
      ST_MKI: begin
        mul_a = pdsd_pkg::mul_a_t'({1'b0, integral_gain});
        mul_b = integ;
      end
      ST_MSS: begin
        mul_a = pdsd_pkg::mul_a_t'({9'd0, speed_scale});
        mul_b = pdsd_pkg::mul_b_t'(speed);
      end
      ST_MST: begin
        mul_a = pdsd_pkg::mul_a_t'({9'd0, steer_scale});
        mul_b = pdsd_pkg::mul_b_t'(steer);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      integ     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != ST_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_ERR;
          end
        end
        ST_ERR: begin
          if (meas == 16'd0) begin
            state <= ST_FIN;
          end else begin
            state <= ST_INT;
          end
        end
        ST_INT: begin
          if (err_outside) begin
            integ <= sum_clamped;
          end
          state <= ST_MKI;
        end
        ST_MKI: state <= ST_ACC;
        ST_ACC: state <= ST_SPD;
        ST_SPD: state <= ST_MSS;
        ST_MSS: state <= ST_MST;
        ST_MST: state <= ST_MIX;
        ST_MIX: state <= ST_FIN;
        ST_FIN: begin
          // hold the result until the output register frees up
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        meas <= distance;
        line <= line_position;
      end
      ST_ERR: begin
        err       <= 17'({1'b0, meas}) - 17'({1'b0, setpoint});
        steer     <= 11'({1'b0, line}) - LINE_HALF;
        res_right <= '0;
        res_left  <= '0;
        res_seen  <= 1'b0;
      end
      ST_INT: begin
        active <= err_outside;
        if (steer_abs < 11'(steer_deadband)) begin
          steer <= '0;
        end
      end
      ST_MKI: acc <= prod_ext;
      ST_ACC: acc <= acc + prod_ext;
      ST_SPD: speed <= active ? pdsd_pkg::sat16(acc_q) : 16'sd0;
      ST_MST: acc <= prod_ext;
      ST_MIX: begin
        res_right <= pdsd_pkg::sat16(acc - prod_ext);
        res_left  <= pdsd_pkg::sat16(acc + prod_ext);
        res_seen  <= 1'b1;
      end
      ST_FIN: begin
        if (out_free) begin
          right_speed <= res_right;
          left_speed  <= res_left;
          target_seen <= res_seen;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire
